### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### hw/rtl/lcdnw_pkg.sv
package lcdnw_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_INIT  = 2'd0,
      REQ_CMD   = 2'd1,
      REQ_DATA  = 2'd2,
      REQ_PLACE = 2'd3
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_ENABLE_PHASE = 3'd0,
      CSR_RS_SETUP     = 3'd1,
      CSR_POWER_UP     = 3'd2,
      CSR_INIT_GAP     = 3'd3,
      CSR_INIT_SETTLE  = 3'd4
   } csr_index_type;

   // operations handed from the front to the back
   typedef enum logic [2:0] {
      OP_BYTE        = 3'd0,
      OP_STROBE      = 3'd1,
      OP_WAIT_PWR    = 3'd2,
      OP_WAIT_GAP    = 3'd3,
      OP_WAIT_SETTLE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_INIT,
      FR_PLACE,
      FR_DATA
   } front_state_type;

   typedef struct packed {
      op_type     op;
      logic       rs;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [9:0]  enable_phase_us;
      logic [15:0] rs_setup_us;
      logic [19:0] power_up_us;
      logic [15:0] init_gap_us;
      logic [19:0] init_settle_us;
   } cfg_type;

   localparam logic [9:0]  RST_ENABLE_PHASE = 10'd40;
   localparam logic [15:0] RST_RS_SETUP     = 16'd2000;
   localparam logic [19:0] RST_POWER_UP     = 20'd100000;
   localparam logic [15:0] RST_INIT_GAP     = 16'd1000;
   localparam logic [19:0] RST_INIT_SETTLE  = 20'd100000;

   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] PLACE_LINE1    = 8'h7F;
   localparam logic [7:0] PLACE_LINE2    = 8'hBF;
   localparam logic [7:0] LINE_ONE       = 8'd1;
   localparam logic [7:0] LINE_TWO       = 8'd2;
   localparam logic [7:0] NIB_WAKE       = 8'h03;
   localparam logic [7:0] NIB_FOUR_BIT   = 8'h02;
   localparam logic [7:0] NIB_SETTLE     = 8'h01;
   localparam logic [7:0] NIB_ZERO       = 8'h00;

   localparam int unsigned INIT_CMDS = 14;
   localparam logic [3:0]  INIT_LAST_IDX = 4'(INIT_CMDS - 1);

   // power-up command list, one entry per queued operation
   function automatic cmd_type init_cmd(input logic [3:0] idx);
      cmd_type c;
      c.rs   = 1'b0;
      c.last = 1'b0;
      c.op   = OP_STROBE;
      c.data = NIB_WAKE;
      unique case (idx)
         4'd0: begin
            c.op   = OP_WAIT_PWR;
            c.data = NIB_ZERO;
         end
         4'd1, 4'd2, 4'd3: begin
            c.op   = OP_STROBE;
            c.data = NIB_WAKE;
         end
         4'd4: begin
            c.op   = OP_WAIT_GAP;
            c.data = NIB_WAKE;
         end
         4'd5, 4'd6, 4'd7: begin
            c.op   = OP_STROBE;
            c.data = NIB_FOUR_BIT;
         end
         4'd8: begin
            c.op   = OP_WAIT_GAP;
            c.data = NIB_FOUR_BIT;
         end
         4'd9: begin
            c.op   = OP_BYTE;
            c.data = CMD_FUNC_SET;
         end
         4'd10: begin
            c.op   = OP_BYTE;
            c.data = CMD_DISP_ON;
         end
         4'd11: begin
            c.op   = OP_BYTE;
            c.data = CMD_ENTRY_MODE;
         end
         4'd12: begin
            c.op   = OP_BYTE;
            c.data = CMD_CLEAR;
         end
         default: begin
            c.op   = OP_WAIT_SETTLE;
            c.data = NIB_SETTLE;
            c.last = 1'b1;
         end
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/lcdnw_front.sv
`include "assert_macros.svh"

module lcdnw_front import lcdnw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [23:0]  req_tdata,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   front_state_type state_ff, state_in;
   logic [3:0]      idx_ff, idx_in;
   logic            rs_ff, rs_in;
   logic [7:0]      byte_ff, byte_in;
   logic [7:0]      place_ff, place_in;

   logic [7:0]      in_byte, in_line, in_col;
   req_kind_type    in_kind;

   assign in_byte = req_tdata[7:0];
   assign in_line = req_tdata[15:8];
   assign in_col  = req_tdata[23:16];
   assign in_kind = req_kind_type'(req_tuser);

   assign req_tready = (state_ff == FR_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      rs_ff    <= rs_in;
      byte_ff  <= byte_in;
      place_ff <= place_in;
   end

   // classify the request and queue its operations one per cycle unless q_full
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rs_in    = rs_ff;
      byte_in  = byte_ff;
      place_in = place_ff;
      q_push   = 1'b0;
      q_cmd    = init_cmd(idx_ff);
      unique case (state_ff)
         FR_IDLE: begin
            if (req_tvalid) begin
               idx_in  = 4'd0;
               byte_in = in_byte;
               rs_in   = 1'b1;
               unique case (in_kind)
                  REQ_INIT: state_in = FR_INIT;
                  REQ_CMD: begin
                     rs_in    = 1'b0;
                     state_in = FR_DATA;
                  end
                  REQ_DATA: state_in = FR_DATA;
                  default: begin
                     if (in_line == LINE_ONE) begin
                        place_in = in_col + PLACE_LINE1;
                        state_in = FR_PLACE;
                     end else if (in_line == LINE_TWO) begin
                        place_in = in_col + PLACE_LINE2;
                        state_in = FR_PLACE;
                     end else begin
                        state_in = FR_DATA;
                     end
                  end
               endcase
            end
         end
         FR_INIT: begin
            q_cmd = init_cmd(idx_ff);
            if (!q_full) begin
               q_push = 1'b1;
               idx_in = idx_ff + 4'd1;
               if (idx_ff == INIT_LAST_IDX) begin
                  state_in = FR_IDLE;
               end
            end
         end
         FR_PLACE: begin
            q_cmd.op   = OP_BYTE;
            q_cmd.rs   = 1'b0;
            q_cmd.data = place_ff;
            q_cmd.last = 1'b0;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FR_DATA;
            end
         end
         default: begin
            q_cmd.op   = OP_BYTE;
            q_cmd.rs   = rs_ff;
            q_cmd.data = byte_ff;
            q_cmd.last = 1'b1;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FR_IDLE;
            end
         end
      endcase
   end

   `ASSERT_CLK(a_idle_no_push, (state_ff == FR_IDLE) |-> !q_push,
      "front queued an operation while idle")
   `ASSERT_CLK(a_last_leaves, (q_push && q_cmd.last) |=> (state_ff == FR_IDLE),
      "front stayed busy after queuing the final operation")

endmodule

### hw/rtl/lcdnw_queue.sv
`include "assert_macros.svh"

module lcdnw_queue import lcdnw_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

   cmd_type         slots_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full       = (cnt_ff == CNT_MAX);
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slots_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_MAX) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_MAX) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_cmd;
      end
   end

   `ASSERT_CLK(a_count_tracks,
      cnt_ff == $past(cnt_ff) + CW'($past(do_push)) - CW'($past(do_pop)) || $past(reset),
      "queue fill count lost track of pushes and pops")

endmodule

### hw/rtl/lcdnw_back.sv
`include "assert_macros.svh"

module lcdnw_back import lcdnw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_rs,
   output logic [3:0]   rsp_nibble,
   output logic         rsp_enable,
   output logic [19:0]  rsp_hold_us,
   output logic         rsp_last
);

   localparam logic [2:0] STEP_BYTE_END   = 3'd6;
   localparam logic [2:0] STEP_STROBE_END = 3'd2;

   cmd_type      cur_ff, cur_in;
   logic         busy_ff, busy_in;
   logic [2:0]   step_ff, step_in;
   logic         valid_ff, valid_in;
   logic         rs_ff, rs_in;
   logic [3:0]   nib_ff, nib_in;
   logic         en_ff, en_in;
   logic [19:0]  hold_ff, hold_in;
   logic         last_ff, last_in;

   logic         advance, fire, final_step, load;
   logic [3:0]   e_nib;
   logic         e_en;
   logic [19:0]  e_hold;
   logic [19:0]  phase_hold;

   assign phase_hold = 20'(cfg.enable_phase_us);

   // pin state for the current operation step
   always_comb begin
      e_nib      = cur_ff.data[3:0];
      e_en       = 1'b0;
      e_hold     = phase_hold;
      final_step = 1'b1;
      unique case (cur_ff.op)
         OP_BYTE: begin
            final_step = (step_ff == STEP_BYTE_END);
            e_nib      = (step_ff < 3'd4) ? cur_ff.data[7:4] : cur_ff.data[3:0];
            e_en       = (step_ff == 3'd2) || (step_ff == 3'd5);
            e_hold     = (step_ff == 3'd0) ? 20'(cfg.rs_setup_us) : phase_hold;
         end
         OP_STROBE: begin
            final_step = (step_ff == STEP_STROBE_END);
            e_en       = (step_ff == 3'd1);
         end
         OP_WAIT_PWR:    e_hold = cfg.power_up_us;
         OP_WAIT_GAP:    e_hold = 20'(cfg.init_gap_us);
         default:        e_hold = cfg.init_settle_us;
      endcase
   end

   // step sequencing and output register
   always_comb begin
      advance  = !valid_ff || rsp_tready;
      fire     = busy_ff && advance;
      load     = q_valid && (!busy_ff || (fire && final_step));
      q_pop    = load;
      cur_in   = load ? q_cmd : cur_ff;
      busy_in  = load ? 1'b1 : ((fire && final_step) ? 1'b0 : busy_ff);
      step_in  = (load || (fire && final_step)) ? 3'd0 :
                 (fire ? step_ff + 3'd1 : step_ff);
      valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      rs_in    = fire ? cur_ff.rs : rs_ff;
      nib_in   = fire ? e_nib : nib_ff;
      en_in    = fire ? e_en : en_ff;
      hold_in  = fire ? e_hold : hold_ff;
      last_in  = fire ? (cur_ff.last && final_step) : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      rs_ff   <= rs_in;
      nib_ff  <= nib_in;
      en_ff   <= en_in;
      hold_ff <= hold_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_rs      = rs_ff;
   assign rsp_nibble  = nib_ff;
   assign rsp_enable  = en_ff;
   assign rsp_hold_us = hold_ff;
   assign rsp_last    = last_ff;

   `ASSERT_CLK(a_step_range, step_ff <= STEP_BYTE_END,
      "operation step counter ran past a byte write")
   `ASSERT_CLK(a_strobe_not_last, (valid_ff && en_ff) |-> !last_ff,
      "a request ended with the enable strobe high")

endmodule

### hw/rtl/char_lcd_nibble_write_sequencer.sv
// channel | direction | handshake               | payload
// req     | in        | req_tvalid / req_tready | tuser kind, tdata byte/line/column
// rsp     | out       | rsp_tvalid / rsp_tready | tdata pin state + hold, tlast
// csr     | in        | csr_we                  | csr_index, csr_wdata
//
// a request yields 7 to 50 pin-state words, one per cycle while rsp_tready is high;
// the first word passes the front state, a queue slot, cur_ff and output register.
// the front queues one operation per cycle unless the queue is full and takes the
// next request once the last operation of the current one is queued; the back sets
// the word rate. reset is synchronous and active high; it empties the queue and
// restores the register defaults; a stalled word holds in the output register.
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_kind_type
   input  logic [23:0]  req_tdata,   // data_byte, line, column
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // rs, nibble, enable, hold_us, zero fill
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          q_full, q_push, q_pop, q_valid;
   cmd_type       push_cmd, head_cmd;
   logic          o_rs, o_en;
   logic [3:0]    o_nib;
   logic [19:0]   o_hold;

   // register writes, values cut to their widths
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE_PHASE: cfg_in.enable_phase_us = csr_wdata[9:0];
            CSR_RS_SETUP:     cfg_in.rs_setup_us     = csr_wdata[15:0];
            CSR_POWER_UP:     cfg_in.power_up_us     = csr_wdata;
            CSR_INIT_GAP:     cfg_in.init_gap_us     = csr_wdata[15:0];
            CSR_INIT_SETTLE:  cfg_in.init_settle_us  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_phase_us <= RST_ENABLE_PHASE;
         cfg_ff.rs_setup_us     <= RST_RS_SETUP;
         cfg_ff.power_up_us     <= RST_POWER_UP;
         cfg_ff.init_gap_us     <= RST_INIT_GAP;
         cfg_ff.init_settle_us  <= RST_INIT_SETTLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdnw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   lcdnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   lcdnw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_rs      (o_rs),
      .rsp_nibble  (o_nib),
      .rsp_enable  (o_en),
      .rsp_hold_us (o_hold),
      .rsp_last    (rsp_tlast)
   );

   // output word packing
   assign rsp_tdata = {6'd0, o_hold, o_en, o_nib, o_rs};

endmodule
